// ===== rtl/core/mta_pkg.sv =====
package mta_pkg;

   localparam int TILE_W = 12;
   localparam int CNT_W  = 5;

   typedef enum logic [2:0] {
      CSR_TILE_ROWS_PX   = 3'd0,
      CSR_TILE_COLS_PX   = 3'd1,
      CSR_TILE_HEIGHT_KM = 3'd2,
      CSR_TILE_WIDTH_KM  = 3'd3,
      CSR_TILES_PER_ROW  = 3'd4,
      CSR_TILE_LIMIT     = 3'd5
   } csr_index_type;

   localparam logic [12:0] RST_TILE_ROWS_PX   = 13'd2000;
   localparam logic [12:0] RST_TILE_COLS_PX   = 13'd2000;
   localparam logic [7:0]  RST_TILE_HEIGHT_KM = 8'd10;
   localparam logic [7:0]  RST_TILE_WIDTH_KM  = 8'd10;
   localparam logic [6:0]  RST_TILES_PER_ROW  = 7'd20;
   localparam logic [4:0]  RST_TILE_LIMIT     = 5'd4;

   typedef struct packed {
      logic [12:0] tile_rows_px;
      logic [12:0] tile_cols_px;
      logic [7:0]  tile_height_km;
      logic [7:0]  tile_width_km;
      logic [6:0]  tiles_per_row;
      logic [4:0]  tile_limit;
   } cfg_type;

   typedef struct packed {
      logic              func;
      logic [TILE_W-1:0] tile_id;
      logic [TILE_W-1:0] row_in_tile;
      logic [TILE_W-1:0] col_in_tile;
      logic              was_clamped;
   } job_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile_id;
      logic [TILE_W-1:0] row_in_tile;
      logic [TILE_W-1:0] col_in_tile;
      logic [3:0]        slot;
      logic              load_request;
      logic              table_full;
      logic              was_clamped;
      logic [CNT_W-1:0]  resident_count;
      logic              over_limit;
   } rsp_type;

endpackage

// ===== rtl/core/mta_div.sv =====
module mta_div #(
   parameter int NW  = 29,
   parameter int DW  = 16,
   parameter int SCW = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [NW-1:0]  dividend,
   input  logic [DW-1:0]  divisor,
   input  logic [SCW-1:0] steps,
   output logic           fin,
   output logic [NW-1:0]  quotient,
   output logic [DW-1:0]  remainder
);

   logic [NW-1:0]  dvd_ff, dvd_in;
   logic [DW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  div_ff, div_in;
   logic [SCW-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           fin_ff, fin_in;
   logic [DW:0]    rem_sh;
   logic [DW:0]    diff;

   // One quotient bit per cycle; quotient bits shift in behind the dividend.
   assign rem_sh = {rem_ff, dvd_ff[NW-1]};
   assign diff   = rem_sh - {1'b0, div_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[NW-2:0], ~diff[DW]};
         rem_in = diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
         cnt_in = cnt_ff - SCW'(1);
         if (cnt_ff == SCW'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
      end
   end

   assign fin       = fin_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/mta_front.sv =====
module mta_front #(
   parameter int FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic signed [16:0]    req_x_stereo,
   input  logic signed [16:0]    req_y_stereo,
   input  mta_pkg::cfg_type      cfg,
   output logic                  push,
   output mta_pkg::job_type      job,
   input  logic                  q_full
);
   import mta_pkg::*;

   localparam int MW  = FRAC_BITS + 8;
   localparam int NW  = MW + 13;
   localparam int DW  = (MW > 13) ? MW : 13;
   localparam int SW  = (FRAC_BITS + 9 > 18) ? FRAC_BITS + 9 : 18;
   localparam int IW  = 21;
   localparam int SCW = $clog2(NW + 1);
   localparam logic signed [SW-1:0] LIM = SW'(99 << FRAC_BITS);
   localparam logic signed [SW-1:0] HUN = SW'(100 << FRAC_BITS);

   typedef enum logic [7:0] {
      F_IDLE = 8'b0000_0001,
      F_MUL  = 8'b0000_0010,
      F_DS1  = 8'b0000_0100,
      F_DW1  = 8'b0000_1000,
      F_DS2  = 8'b0001_0000,
      F_DW2  = 8'b0010_0000,
      F_ID   = 8'b0100_0000,
      F_PUSH = 8'b1000_0000
   } fstate_type;

   fstate_type      state_ff, state_in;
   logic            func_ff, func_in;
   logic            clamp_ff, clamp_in;
   logic [MW-1:0]   mx_ff, mx_in, my_ff, my_in;
   logic [NW-1:0]   px_ff, px_in, py_ff, py_in;
   logic [27:0]     idp_ff, idp_in;

   logic signed [SW-1:0] xs, ys, cx, cy, sx, sy;
   logic            hit_x, hit_y;
   logic [7:0]      h_nz, w_nz;
   logic [12:0]     r_nz, c_nz;
   logic            div_start, first;
   logic [NW-1:0]   y_dvd, x_dvd, y_quo, x_quo;
   logic [DW-1:0]   y_dvs, x_dvs, y_rem, x_rem;
   logic [SCW-1:0]  steps;
   logic            y_fin, x_fin;
   logic [28:0]     id_sum;
   logic [12:0]     ri, rj;

   assign xs = SW'(req_x_stereo);
   assign ys = SW'(req_y_stereo);

   always_comb begin
      hit_x = (xs >= LIM) || (xs <= -LIM);
      hit_y = (ys >= LIM) || (ys <= -LIM);
      cx = (xs >= LIM) ? LIM : ((xs <= -LIM) ? -LIM : xs);
      cy = (ys >= LIM) ? LIM : ((ys <= -LIM) ? -LIM : ys);
      sx = cx + HUN;
      sy = HUN - cy;
   end

   assign h_nz = (cfg.tile_height_km == 8'd0) ? 8'd1 : cfg.tile_height_km;
   assign w_nz = (cfg.tile_width_km == 8'd0) ? 8'd1 : cfg.tile_width_km;
   assign r_nz = (cfg.tile_rows_px == 13'd0) ? 13'd1 : cfg.tile_rows_px;
   assign c_nz = (cfg.tile_cols_px == 13'd0) ? 13'd1 : cfg.tile_cols_px;

   // First pass: pixel index from scaled km. Second pass: split into tile and offset.
   assign first     = (state_ff == F_DS1);
   assign div_start = (state_ff == F_DS1) || (state_ff == F_DS2);
   assign steps     = first ? SCW'(NW) : SCW'(IW);
   assign y_dvd     = first ? py_ff : (NW'(y_quo[IW-1:0]) << FRAC_BITS);
   assign x_dvd     = first ? px_ff : (NW'(x_quo[IW-1:0]) << FRAC_BITS);
   assign y_dvs     = first ? (DW'(h_nz) << FRAC_BITS) : DW'(r_nz);
   assign x_dvs     = first ? (DW'(w_nz) << FRAC_BITS) : DW'(c_nz);

   mta_div #(.NW(NW), .DW(DW), .SCW(SCW)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start), .dividend(y_dvd),
      .divisor(y_dvs), .steps(steps), .fin(y_fin), .quotient(y_quo),
      .remainder(y_rem)
   );

   mta_div #(.NW(NW), .DW(DW), .SCW(SCW)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start), .dividend(x_dvd),
      .divisor(x_dvs), .steps(steps), .fin(x_fin), .quotient(x_quo),
      .remainder(x_rem)
   );

   assign ri     = y_rem[12:0];
   assign rj     = x_rem[12:0];
   assign id_sum = 29'(idp_ff) + 29'(x_quo[IW-1:0]);

   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      clamp_in = clamp_ff;
      mx_in    = mx_ff;
      my_in    = my_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      idp_in   = idp_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               clamp_in = hit_x || hit_y;
               mx_in    = sx[MW-1:0];
               my_in    = sy[MW-1:0];
               state_in = req_func ? F_PUSH : F_MUL;
            end
         end
         F_MUL: begin
            px_in    = NW'(mx_ff) * NW'(cfg.tile_cols_px);
            py_in    = NW'(my_ff) * NW'(cfg.tile_rows_px);
            state_in = F_DS1;
         end
         F_DS1: state_in = F_DW1;
         F_DW1: begin
            if (y_fin && x_fin) state_in = F_DS2;
         end
         F_DS2: state_in = F_DW2;
         F_DW2: begin
            if (y_fin && x_fin) state_in = F_ID;
         end
         F_ID: begin
            idp_in   = 28'(cfg.tiles_per_row) * 28'(y_quo[IW-1:0]);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      clamp_ff <= clamp_in;
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      idp_ff   <= idp_in;
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != F_IDLE);
   assign push      = (state_ff == F_PUSH) && !q_full;

   always_comb begin
      job = '0;
      job.func = func_ff;
      if (!func_ff) begin
         job.tile_id     = (id_sum > 29'd4095) ? 12'd4095 : id_sum[11:0];
         job.row_in_tile = (ri > 13'd4095) ? 12'd4095 : ri[11:0];
         job.col_in_tile = (rj > 13'd4095) ? 12'd4095 : rj[11:0];
         job.was_clamped = clamp_ff;
      end
   end

endmodule

// ===== rtl/core/mta_queue.sv =====
module mta_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mta_pkg::job_type din,
   output logic             full,
   input  logic             pop,
   output logic             nempty,
   output mta_pkg::job_type dout
);
   import mta_pkg::*;

   job_type     ent_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= din;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign full   = (cnt_ff == 2'd2);
   assign nempty = (cnt_ff != 2'd0);
   assign dout   = ent_ff[rd_ptr_ff];

endmodule

// ===== rtl/core/mta_back.sv =====
module mta_back #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_nempty,
   input  mta_pkg::job_type q_dout,
   output logic             q_pop,
   input  logic [4:0]       tile_limit,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mta_pkg::rsp_type rsp
);
   import mta_pkg::*;

   localparam int IDXW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW   = $clog2(TABLE_SLOTS + 1);
   localparam logic [IDXW-1:0] LAST = IDXW'(TABLE_SLOTS - 1);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_SCAN = 3'b010,
      B_FIN  = 3'b100
   } bstate_type;

   bstate_type             state_ff, state_in;
   job_type                job_ff, job_in;
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in, used_ff, used_in;
   logic [IDXW-1:0]        rd_idx_ff, rd_idx_in, cmp_idx_ff, cmp_idx_in;
   logic                   issue_ff, issue_in, cmp_vld_ff, cmp_vld_in;
   logic                   hit_found_ff, hit_found_in, free_found_ff, free_found_in;
   logic [IDXW-1:0]        hit_slot_ff, hit_slot_in, free_slot_ff, free_slot_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [TILE_W-1:0]      rd_q_ff;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free, rd_en, wr_en;

   logic [TILE_W-1:0] tile_mem [TABLE_SLOTS];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_en    = (state_ff == B_SCAN) && issue_ff;
   assign wr_en    = (state_ff == B_FIN) && out_free && !job_ff.func
                     && !hit_found_ff && free_found_ff;

   always_ff @(posedge clock) begin
      if (rd_en) rd_q_ff <= tile_mem[rd_idx_ff];
      if (wr_en) tile_mem[free_slot_ff] <= job_ff.tile_id;
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      hit_found_in  = hit_found_ff;
      free_found_in = free_found_ff;
      hit_slot_in   = hit_slot_ff;
      free_slot_in  = free_slot_ff;
      count_in      = count_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      q_pop         = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (q_nempty) begin
               q_pop         = 1'b1;
               job_in        = q_dout;
               issue_in      = 1'b1;
               rd_idx_in     = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               count_in      = '0;
               state_in      = B_SCAN;
            end
         end
         B_SCAN: begin
            // Read stage: one slot tag per cycle out of the tag memory.
            if (issue_ff) begin
               cmp_idx_in = rd_idx_ff;
               cmp_vld_in = 1'b1;
               if (rd_idx_ff == LAST) issue_in = 1'b0;
               else rd_idx_in = rd_idx_ff + IDXW'(1);
            end
            // Compare stage: the tag read in the previous cycle.
            if (cmp_vld_ff) begin
               if (job_ff.func) begin
                  if (valid_ff[cmp_idx_ff]) begin
                     if (!used_ff[cmp_idx_ff]) begin
                        valid_in[cmp_idx_ff] = 1'b0;
                     end else begin
                        used_in[cmp_idx_ff] = 1'b0;
                        count_in = count_ff + CW'(1);
                     end
                  end
               end else begin
                  if (valid_ff[cmp_idx_ff] && rd_q_ff == job_ff.tile_id && !hit_found_ff) begin
                     hit_found_in = 1'b1;
                     hit_slot_in  = cmp_idx_ff;
                  end
                  if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_slot_in  = cmp_idx_ff;
                  end
               end
               if (cmp_idx_ff == LAST) state_in = B_FIN;
            end
         end
         B_FIN: begin
            if (out_free) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
               if (job_ff.func) begin
                  rsp_in.resident_count = (32'(count_ff) > 32'd31) ? 5'd31 : 5'(count_ff);
                  rsp_in.over_limit     = 32'(count_ff) > 32'(tile_limit);
               end else begin
                  rsp_in.tile_id     = job_ff.tile_id;
                  rsp_in.row_in_tile = job_ff.row_in_tile;
                  rsp_in.col_in_tile = job_ff.col_in_tile;
                  rsp_in.was_clamped = job_ff.was_clamped;
                  if (hit_found_ff) begin
                     rsp_in.slot          = 4'(hit_slot_ff);
                     used_in[hit_slot_ff] = 1'b1;
                  end else if (free_found_ff) begin
                     rsp_in.slot            = 4'(free_slot_ff);
                     rsp_in.load_request    = 1'b1;
                     valid_in[free_slot_ff] = 1'b1;
                     used_in[free_slot_ff]  = 1'b1;
                  end else begin
                     rsp_in.table_full = 1'b1;
                  end
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_found_ff  <= hit_found_in;
      free_found_ff <= free_found_in;
      hit_slot_ff   <= hit_slot_in;
      free_slot_ff  <= free_slot_in;
      count_ff      <= count_in;
      rsp_ff        <= rsp_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         valid_ff     <= '0;
         used_ff      <= '0;
         issue_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         used_ff      <= used_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/core/map_tile_address_and_residency_unit.sv =====
// Map tile address and residency unit.
// Request channel (req_valid/req_stall): req_func 0 looks up a stereographic
// point, 1 sweeps the residency table. Each request gives exactly one transfer
// on the response channel (rsp_valid/rsp_stall), in request order.
// Configuration (csr_valid/csr_ready, csr_index, csr_wdata) is always ready and
// should only be written while no request is in flight.
// A lookup passes through two rounds of restoring division in the front end,
// one quotient bit per cycle (x and y in parallel); the back end then scans
// the tag memory one slot per cycle. A sweep skips the dividers. One request
// is taken per front-end pass; a two-entry queue lets the front end work on
// the next request while the back end scans.
// Reset empties the table and the queue and loads the default registers.
// When the receiver stalls, the response holds and the back end finishes its
// scan, then waits; the queue fills and req_stall rises.
module map_tile_address_and_residency_unit #(
   parameter int TABLE_SLOTS = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic signed [16:0]     req_x_stereo,
   input  logic signed [16:0]     req_y_stereo,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [11:0]            rsp_tile_id,
   output logic [11:0]            rsp_row_in_tile,
   output logic [11:0]            rsp_col_in_tile,
   output logic [3:0]             rsp_slot,
   output logic                   rsp_load_request,
   output logic                   rsp_table_full,
   output logic                   rsp_was_clamped,
   output logic [4:0]             rsp_resident_count,
   output logic                   rsp_over_limit,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [12:0]            csr_wdata
);
   import mta_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type q_din, q_dout;
   rsp_type rsp;
   logic    q_push, q_full, q_pop, q_nempty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TILE_ROWS_PX:   cfg_in.tile_rows_px   = csr_wdata;
            CSR_TILE_COLS_PX:   cfg_in.tile_cols_px   = csr_wdata;
            CSR_TILE_HEIGHT_KM: cfg_in.tile_height_km = csr_wdata[7:0];
            CSR_TILE_WIDTH_KM:  cfg_in.tile_width_km  = csr_wdata[7:0];
            CSR_TILES_PER_ROW:  cfg_in.tiles_per_row  = csr_wdata[6:0];
            CSR_TILE_LIMIT:     cfg_in.tile_limit     = csr_wdata[4:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tile_rows_px   <= RST_TILE_ROWS_PX;
         cfg_ff.tile_cols_px   <= RST_TILE_COLS_PX;
         cfg_ff.tile_height_km <= RST_TILE_HEIGHT_KM;
         cfg_ff.tile_width_km  <= RST_TILE_WIDTH_KM;
         cfg_ff.tiles_per_row  <= RST_TILES_PER_ROW;
         cfg_ff.tile_limit     <= RST_TILE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mta_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_x_stereo(req_x_stereo), .req_y_stereo(req_y_stereo),
      .cfg(cfg_ff), .push(q_push), .job(q_din), .q_full(q_full)
   );

   mta_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .din(q_din), .full(q_full),
      .pop(q_pop), .nempty(q_nempty), .dout(q_dout)
   );

   mta_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
      .clock(clock), .reset(reset), .q_nempty(q_nempty), .q_dout(q_dout),
      .q_pop(q_pop), .tile_limit(cfg_ff.tile_limit), .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall), .rsp(rsp)
   );

   assign rsp_tile_id        = rsp.tile_id;
   assign rsp_row_in_tile    = rsp.row_in_tile;
   assign rsp_col_in_tile    = rsp.col_in_tile;
   assign rsp_slot           = rsp.slot;
   assign rsp_load_request   = rsp.load_request;
   assign rsp_table_full     = rsp.table_full;
   assign rsp_was_clamped    = rsp.was_clamped;
   assign rsp_resident_count = rsp.resident_count;
   assign rsp_over_limit     = rsp.over_limit;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("queue written while full");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_nempty) else $error("queue read while empty");

   a_miss_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_load_request && rsp_table_full))
      else $error("load request and full table in one response");

   a_sweep_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_resident_count != 5'd0) |-> (rsp_tile_id == 12'd0 && rsp_slot == 4'd0))
      else $error("sweep response carries lookup fields");

endmodule
